// ===== hdl/sba_pkg.sv =====
package sba_pkg;

    localparam int NODE_W  = 8;
    localparam int VALUE_W = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 5'd16;

    // Stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((NODE_W + VALUE_W + TIME_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VALUE_W + TIME_W + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SUM  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

endpackage

// ===== hdl/sensor_barrier_average_core.sv =====
// Barrier average of sensor reports. Each input beat carries one report (node number, Q8.8
// reading, millisecond timestamp); the reading is written to the node's entry in a store with
// one write port and one read port, and the node is marked as reported. Reports from node 0 or
// from a node above the effective count (node_count clamped to 1..MAX_NODES) are dropped
// without effect. When every node 1..count holds a mark, the block clears all marks and emits
// one result beat: the sum of the stored readings divided by the count, truncated toward
// zero, with the timestamp of the completing report. A report that does not complete the set
// leaves the block idle and ready for the next report. A completing report reads the store
// one entry a cycle through its registered read port and adds each reading, then passes the
// sum through the bit-serial divider (NUM_W is 17 plus the node index width, 21 for 16
// nodes), then loads the result into the output register once that register is free.
// Reports are taken again as soon as the result sits in the output register, even while it
// still waits for m_tready. The store needs no clearing pass after reset: an entry is only
// summed once its node has reported.
module sensor_barrier_average_core #(
    parameter int MAX_NODES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // tdata: node_number [7:0], sensor_value [23:8], time_ms [55:24]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sba_pkg::IN_DATA_W-1:0]     s_tdata,
    // tdata: mean_value [15:0], mean_time_ms [47:16]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sba_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sba_pkg::CFG_W-1:0]         cfg_data
);

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int SUM_W = sba_pkg::VALUE_W + 1 + IDX_W;
    localparam int CMP_W = ((CNT_W > sba_pkg::CFG_W) ? CNT_W : sba_pkg::CFG_W) + 1;
    localparam int NCMP_W = sba_pkg::NODE_W + 1;

    sba_pkg::state_t                     state_reg, state_next;
    logic [sba_pkg::CFG_W-1:0]           node_count_reg;
    logic [MAX_NODES-1:0]                mask_reg, mask_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic [CNT_W-1:0]                    rd_ptr_reg, rd_ptr_next;
    logic                                pend_reg, pend_next;
    logic signed [SUM_W-1:0]             sum_reg, sum_next;
    logic [sba_pkg::TIME_W-1:0]          stamp_reg, stamp_next;
    logic                                m_valid_reg, m_valid_next;
    logic [sba_pkg::OUT_DATA_W-1:0]      m_data_reg, m_data_next;

    logic [CNT_W-1:0]                    count_eff;
    logic [sba_pkg::NODE_W-1:0]          in_node;
    logic signed [sba_pkg::VALUE_W-1:0]  in_value;
    logic [sba_pkg::TIME_W-1:0]          in_time;
    logic                                in_acc;
    logic                                node_ok;
    logic [IDX_W-1:0]                    node_idx;
    logic [MAX_NODES-1:0]                need_mask;
    logic [MAX_NODES-1:0]                new_mask;
    logic                                set_full;
    logic                                rd_en;
    logic signed [sba_pkg::VALUE_W-1:0]  rd_data;
    logic                                sum_done;
    logic                                div_start;
    logic                                div_done;
    logic signed [SUM_W-1:0]             quotient;

    // Unpack the input beat
    assign in_node  = s_tdata[sba_pkg::NODE_W-1:0];
    assign in_value = s_tdata[sba_pkg::NODE_W +: sba_pkg::VALUE_W];
    assign in_time  = s_tdata[sba_pkg::NODE_W + sba_pkg::VALUE_W +: sba_pkg::TIME_W];

    assign s_tready = (state_reg == sba_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Clamp the register to 1..MAX_NODES
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (CMP_W'(node_count_reg) > CMP_W'(MAX_NODES))
        begin
            count_eff = CNT_W'(MAX_NODES);
        end
        else
        begin
            count_eff = CNT_W'(node_count_reg);
        end
    end

    assign node_ok  = (in_node != '0) && (NCMP_W'(in_node) <= NCMP_W'(count_eff));
    assign node_idx = IDX_W'(in_node - 1'b1);

    // Marks that must be present for the set to complete
    always_comb
    begin
        for (int i = 0; i < MAX_NODES; i++)
        begin
            need_mask[i] = (CNT_W'(i) < count_eff);
        end
    end

    assign new_mask = mask_reg | (MAX_NODES'(1) << node_idx);
    assign set_full = &(new_mask | ~need_mask);

    // Summing pass: issue one read a cycle, add the data in the following cycle
    assign rd_en     = (state_reg == sba_pkg::ST_SUM) && (rd_ptr_reg != count_reg);
    assign sum_done  = (state_reg == sba_pkg::ST_SUM) && (rd_ptr_reg == count_reg) && !pend_reg;
    assign div_start = sum_done;

    always_comb
    begin
        state_next   = state_reg;
        mask_next    = mask_reg;
        count_next   = count_reg;
        rd_ptr_next  = rd_ptr_reg;
        pend_next    = 1'b0;
        sum_next     = sum_reg;
        stamp_next   = stamp_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // Drop the result beat once taken
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            sba_pkg::ST_IDLE:
            begin
                if (in_acc && node_ok)
                begin
                    if (set_full)
                    begin
                        mask_next   = '0;
                        count_next  = count_eff;
                        rd_ptr_next = '0;
                        sum_next    = '0;
                        stamp_next  = in_time;
                        state_next  = sba_pkg::ST_SUM;
                    end
                    else
                    begin
                        mask_next = new_mask;
                    end
                end
            end
            sba_pkg::ST_SUM:
            begin
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(rd_data);
                end
                if (rd_en)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    pend_next   = 1'b1;
                end
                if (sum_done)
                begin
                    state_next = sba_pkg::ST_DIV;
                end
            end
            sba_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = sba_pkg::ST_OUT;
                end
            end
            sba_pkg::ST_OUT:
            begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {stamp_reg, quotient[sba_pkg::VALUE_W-1:0]};
                    state_next   = sba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sba_pkg::ST_IDLE;
            node_count_reg <= sba_pkg::NODE_COUNT_RESET;
            mask_reg       <= '0;
            rd_ptr_reg     <= '0;
            pend_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mask_reg    <= mask_next;
            rd_ptr_reg  <= rd_ptr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        sum_reg    <= sum_next;
        stamp_reg  <= stamp_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Writes happen only in idle and reads only in the summing pass, so the
    // two never touch the same entry in one cycle.
    sba_store #(
        .DEPTH  (MAX_NODES),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (in_acc && node_ok),
        .wr_addr (node_idx),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    sba_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // A completing report leaves no marks behind
    a_mask_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && node_ok && set_full) |=> (mask_reg == '0))
        else $error("marks not cleared after a completed set");

    // The read pointer never runs past the latched count
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sba_pkg::ST_SUM) |-> (rd_ptr_reg <= count_reg))
        else $error("read pointer beyond node count");

    // The divider only finishes while the sequencer waits for it
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == sba_pkg::ST_DIV))
        else $error("divider finished outside the divide phase");

    // A new result beat only appears from the output phase
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == sba_pkg::ST_OUT))
        else $error("result beat raised outside the output phase");

endmodule

// ===== hdl/sba_store.sv =====
module sba_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [ADDR_W-1:0]                   wr_addr,
    input  logic signed [sba_pkg::VALUE_W-1:0]  wr_data,
    input  logic                                rd_en,
    input  logic [ADDR_W-1:0]                   rd_addr,
    output logic signed [sba_pkg::VALUE_W-1:0]  rd_data
);

    logic signed [sba_pkg::VALUE_W-1:0] mem [DEPTH];
    logic signed [sba_pkg::VALUE_W-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/sba_div.sv =====
module sba_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0]        divisor,
    output logic                    done,
    output logic signed [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic                 neg_reg, neg_next;
    logic [DEN_W:0]       shifted;
    logic [DEN_W:0]       diff;

    // Restoring division on magnitudes, one quotient bit a cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = divisor;
            neg_next  = dividend[NUM_W-1];
            quo_next  = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
        end
        else if (busy_reg)
        begin
            if (diff[DEN_W])
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule
